[rtl/gpsk_pkg.sv]
// Shared constants and types for the GPS position settling filter.
`default_nettype none
package gpsk_pkg;
    localparam int unsigned WARMUP_UPDATES = 5;
    localparam int unsigned STABLE_UPDATES = 5;
    localparam int unsigned CNT_W = 3;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [31:0] Q_RESET = 32'd10737;
    localparam logic [31:0] R_RESET = 32'h4000_0000;
    localparam int unsigned DIV_STEPS = 31;
    localparam int unsigned ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_Q = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_RLAT = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_RLON = 4'h8;

    // lane control from the top sequencer
    typedef struct packed {
        logic start;
    } lane_ctl_t;

    // lane status back to the sequencer
    typedef struct packed {
        logic done;
        logic changed;
    } lane_sts_t;
endpackage
`default_nettype wire

[rtl/gpsk_lane.sv]
// One scalar Kalman axis: variance update, iterative gain divider, estimate step.
`default_nettype none
module gpsk_lane (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gpsk_pkg::lane_ctl_t ctl,
    output gpsk_pkg::lane_sts_t     sts,
    input  wire logic [31:0]        q,
    input  wire logic [31:0]        r,
    input  wire logic signed [31:0] z,
    output logic signed [31:0]      est
);
    import gpsk_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PRE  = 6'b000010,
        S_DIV  = 6'b000100,
        S_MUL  = 6'b001000,
        S_UPD  = 6'b010000,
        S_DONE = 6'b100000
    } st_t;

    st_t st_reg;
    logic [31:0] p_reg;
    logic signed [31:0] x_reg;
    logic [32:0] den_reg;
    logic [33:0] rem_reg;
    logic [30:0] quo_reg;
    logic [4:0] step_reg;
    logic [31:0] p1_reg;
    logic [30:0] k_reg;
    logic sign_reg;
    logic [32:0] dmag_reg;
    logic [63:0] pprod_reg;
    logic [63:0] sprod_reg;

    logic [32:0] p1_sum;
    logic [31:0] p1_sat;
    logic signed [32:0] diff;
    logic [34:0] rem_sh;
    logic [34:0] rem_sub;
    logic [30:0] k_sat;
    logic [31:0] stepmag;
    logic signed [32:0] x_new;

    assign p1_sum = {1'b0, p_reg} + {1'b0, q};
    assign p1_sat = p1_sum[32] ? 32'hFFFF_FFFF : p1_sum[31:0];
    assign diff = 33'(z) - 33'(x_reg);
    // restoring divide step; the first step brings in the low bit of p1, later steps zeros
    assign rem_sh = {rem_reg, (step_reg == '0) ? p1_reg[0] : 1'b0};
    assign rem_sub = rem_sh - {2'b00, den_reg};
    assign k_sat = (quo_reg > 31'(ONE_Q30)) ? 31'(ONE_Q30) : quo_reg;
    assign stepmag = sprod_reg[61:30];
    assign x_new = sign_reg ? 33'(x_reg) - 33'(stepmag) : 33'(x_reg) + 33'(stepmag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            p_reg <= ONE_Q30;
            x_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                begin
                    if (ctl.start)
                    begin
                        st_reg <= S_PRE;
                    end
                end
                S_PRE:
                begin
                    p1_reg <= p1_sat;
                    den_reg <= {1'b0, p1_sat} + {1'b0, r};
                    // p1 <= den, so p1*2^30/den has one integer bit and 30 fraction bits
                    rem_reg <= {3'b000, p1_sat[31:1]};
                    quo_reg <= '0;
                    step_reg <= '0;
                    sign_reg <= diff[32];
                    dmag_reg <= diff[32] ? 33'(-diff) : 33'(diff);
                    st_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // step 0 yields the integer bit, the next 30 the fraction bits
                    if (!rem_sub[34])
                    begin
                        rem_reg <= rem_sub[33:0];
                        quo_reg <= {quo_reg[29:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[33:0];
                        quo_reg <= {quo_reg[29:0], 1'b0};
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(DIV_STEPS - 1))
                    begin
                        st_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    k_reg <= (den_reg == '0) ? '0 : k_sat;
                    st_reg <= S_UPD;
                end
                S_UPD:
                begin
                    pprod_reg <= 64'(ONE_Q30 - 32'(k_reg)) * 64'(p1_reg);
                    sprod_reg <= 64'(k_reg) * 64'(dmag_reg);
                    st_reg <= S_DONE;
                end
                S_DONE:
                begin
                    p_reg <= pprod_reg[61:30];
                    x_reg <= x_new[31:0];
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign sts.done = (st_reg == S_DONE);
    assign sts.changed = (stepmag != '0);
    assign est = x_reg;

    // divider only runs in its own state
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != S_DIV |-> step_reg == '0 || step_reg == 5'(DIV_STEPS))
        else $error("divider step counter out of phase");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_DONE |=> st_reg == S_IDLE)
        else $error("lane did not return to idle");
    a_k: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_UPD |-> k_reg <= 31'(ONE_Q30))
        else $error("gain above one");
endmodule
`default_nettype wire

[rtl/gps_position_kalman_settle.sv]
// Top level: config registers, two Kalman lanes, settle tracking and output word.
//
// Usage: input words arrive on s_axis (tdata = meas_latitude[30:0],
// meas_longitude[62:31], zero pad; tuser = fix_valid). One output word per
// input word leaves on m_axis (tdata = est_latitude[30:0],
// est_longitude[62:31], zero pad; tuser = settled).
// A valid fix runs both axes in parallel lanes; each lane steps through S_PRE,
// S_DIV (the 31-step restoring divider for the gain), S_MUL, S_UPD and S_DONE
// before m_axis_tvalid rises. An invalid fix registers
// lanes_done_reg and then m_axis_tvalid. One word is in flight at a time;
// s_axis_tready is low while the lanes run or while a finished word waits in
// the output register. A new word is taken the cycle after the output word
// is accepted. A stalled receiver holds the output word and the block takes
// no new input until it drains.
// Reset restores estimates to zero, variances to 1.0, counters and the
// settled flag to zero, q to 10737 and both r to 1.0.
// The APB port writes q, r_lat, r_lon at byte addresses 0, 4, 8.
`default_nettype none
module gps_position_kalman_settle (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // meas_latitude, meas_longitude
    input  wire logic        s_axis_tuser,  // fix_valid
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // est_latitude, est_longitude
    output logic             m_axis_tuser,  // settled
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [gpsk_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import gpsk_pkg::*;

    logic [31:0] q_reg, rlat_reg, rlon_reg;
    logic busy_reg, pend_reg;
    logic signed [31:0] zlat_reg, zlon_reg;
    logic [CNT_W-1:0] warm_reg, stable_reg;
    logic settled_reg;
    lane_ctl_t ctl;
    lane_sts_t sts_lat, sts_lon;
    logic signed [31:0] est_lat, est_lon;
    logic s_acc, m_acc, lanes_done_reg, lat_done_reg, lon_done_reg;
    logic ch_lat_reg, ch_lon_reg;

    assign pready = 1'b1;
    assign s_acc = s_axis_tvalid & s_axis_tready;
    assign m_acc = m_axis_tvalid & m_axis_tready;
    assign s_axis_tready = !busy_reg && !m_axis_tvalid;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= Q_RESET;
            rlat_reg <= R_RESET;
            rlon_reg <= R_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                ADDR_Q:    q_reg <= pwdata;
                ADDR_RLAT: rlat_reg <= pwdata;
                ADDR_RLON: rlon_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_Q:    prdata = q_reg;
            ADDR_RLAT: prdata = rlat_reg;
            ADDR_RLON: prdata = rlon_reg;
            default:   prdata = '0;
        endcase
    end

    assign ctl.start = pend_reg;

    gpsk_lane u_lat (
        .clk, .rst_n, .ctl, .sts(sts_lat), .q(q_reg), .r(rlat_reg),
        .z(zlat_reg), .est(est_lat)
    );
    gpsk_lane u_lon (
        .clk, .rst_n, .ctl, .sts(sts_lon), .q(q_reg), .r(rlon_reg),
        .z(zlon_reg), .est(est_lon)
    );

    // sequencing, merge and settle tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            warm_reg <= '0;
            stable_reg <= '0;
            settled_reg <= 1'b0;
            m_axis_tvalid <= 1'b0;
            lanes_done_reg <= 1'b0;
            lat_done_reg <= 1'b0;
            lon_done_reg <= 1'b0;
            ch_lat_reg <= 1'b0;
            ch_lon_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= s_acc && s_axis_tuser;
            lanes_done_reg <= (s_acc && !s_axis_tuser) || (lat_done_reg && lon_done_reg);
            if (s_acc)
            begin
                busy_reg <= 1'b1;
                zlat_reg <= 32'(signed'(s_axis_tdata[30:0]));
                zlon_reg <= signed'(s_axis_tdata[62:31]);
            end
            if (lat_done_reg && lon_done_reg)
            begin
                lat_done_reg <= 1'b0;
                lon_done_reg <= 1'b0;
                if (warm_reg < CNT_W'(WARMUP_UPDATES))
                begin
                    warm_reg <= warm_reg + 1'b1;
                end
                else if (!ch_lat_reg && !ch_lon_reg)
                begin
                    if (stable_reg < CNT_W'(STABLE_UPDATES))
                    begin
                        stable_reg <= stable_reg + 1'b1;
                    end
                    if (stable_reg >= CNT_W'(STABLE_UPDATES - 1))
                    begin
                        settled_reg <= 1'b1;
                    end
                end
                else
                begin
                    stable_reg <= '0;
                end
            end
            else
            begin
                if (sts_lat.done)
                begin
                    lat_done_reg <= 1'b1;
                    ch_lat_reg <= sts_lat.changed;
                end
                if (sts_lon.done)
                begin
                    lon_done_reg <= 1'b1;
                    ch_lon_reg <= sts_lon.changed;
                end
            end
            if (lanes_done_reg)
            begin
                busy_reg <= 1'b0;
                m_axis_tvalid <= 1'b1;
            end
            else if (m_acc)
            begin
                m_axis_tvalid <= 1'b0;
            end
        end
    end

    assign m_axis_tdata = {1'b0, est_lon, est_lat[30:0]};
    assign m_axis_tuser = settled_reg;

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !busy_reg)
        else $error("output word while lanes busy");
    a_sync: assert property (@(posedge clk) disable iff (!rst_n)
        sts_lat.done |-> sts_lon.done)
        else $error("lanes out of step");
    a_settle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(settled_reg) |-> warm_reg == CNT_W'(WARMUP_UPDATES))
        else $error("settled during warm-up");
endmodule
`default_nettype wire

[test/gps_position_kalman_settle_tb.sv]
// Testbench for the GPS position settling filter: stream stimulus, predicted results, APB setup.
`default_nettype none
module gps_position_kalman_settle_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gpsk_pkg::*;

    typedef struct {
        logic        fix_valid;
        logic [30:0] lat;
        logic [31:0] lon;
    } fix_t;

    typedef struct {
        logic [30:0] lat;
        logic [31:0] lon;
        logic        settled;
    } estimate_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic m_axis_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    gps_position_kalman_settle dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [31:0] q_noise, r_lat, r_lon;
    longint      lat_x, lon_x;
    logic [31:0] lat_p, lon_p;
    int unsigned warm_cnt, stable_cnt;
    logic        settled_q;

    fix_t      pending_fixes[$];
    estimate_t expected_estimates[$];
    int        errors = 0;
    int        words_out = 0;
    int        valid_fixes = 0;
    int        idle_cycles = 0;
    bit        hold_input = 1'b0;
    bit        in_acc = 1'b0;
    bit        out_acc = 1'b0;
    int        in_gap = 0;
    int        out_wait = 0;

    initial forever #10 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch word %0d %s: got %0d expected %0d", words_out, what, got, want);
        errors++;
    endtask

    // one scalar Kalman axis update
    function automatic void kalman_axis(inout longint x, inout logic [31:0] p,
                                        input logic [31:0] r, input longint z);
        logic [63:0] p1, den, k, mag, step;
        longint diff;
        p1 = 64'(p) + 64'(q_noise);
        if (p1 > 64'hFFFF_FFFF) p1 = 64'hFFFF_FFFF;
        den = p1 + 64'(r);
        k = (den == 0) ? 64'd0 : ((p1 << 30) / den);
        if (k > 64'(ONE_Q30)) k = 64'(ONE_Q30);
        p = 32'(((64'(ONE_Q30) - k) * p1) >> 30);
        diff = z - x;
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        step = (k * mag) >> 30;
        if (diff < 0) x = x - longint'(step);
        else x = x + longint'(step);
    endfunction

    function automatic estimate_t filter_fix(input fix_t f);
        estimate_t e;
        longint pl, po;
        if (f.fix_valid)
        begin
            pl = lat_x;
            po = lon_x;
            kalman_axis(lat_x, lat_p, r_lat, longint'($signed(f.lat)));
            kalman_axis(lon_x, lon_p, r_lon, longint'($signed(f.lon)));
            if (warm_cnt < WARMUP_UPDATES) warm_cnt++;
            else if (pl == lat_x && po == lon_x)
            begin
                if (stable_cnt < STABLE_UPDATES) stable_cnt++;
                if (stable_cnt >= STABLE_UPDATES) settled_q = 1'b1;
            end
            else stable_cnt = 0;
        end
        e.lat = 31'(lat_x);
        e.lon = 32'(lon_x);
        e.settled = settled_q;
        return e;
    endfunction

    // driver: holds a word until taken, then waits a random gap before the next
    always @(negedge clk)
    begin : driver
        fix_t f;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (s_axis_tvalid && !in_acc)
        begin
            s_axis_tvalid <= 1'b1;
        end
        else if (in_gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            in_gap <= in_gap - 1;
        end
        else if (pending_fixes.size() != 0 && !hold_input)
        begin
            f = pending_fixes.pop_front();
            s_axis_tdata <= {1'b0, f.lon, f.lat};
            s_axis_tuser <= f.fix_valid;
            s_axis_tvalid <= 1'b1;
            expected_estimates.push_back(filter_fix(f));
            if (f.fix_valid) valid_fixes++;
            in_gap <= $urandom_range(0, 12);
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: waits a random number of cycles before taking each word
    always @(negedge clk)
    begin : receiver
        int w;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (out_acc)
        begin
            w = $urandom_range(0, 12);
            out_wait <= w;
            m_axis_tready <= (w == 0);
        end
        else if (out_wait > 0)
        begin
            out_wait <= out_wait - 1;
            m_axis_tready <= (out_wait == 1);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin : monitor
        estimate_t e;
        if (rst_n)
        begin
            in_acc <= s_axis_tvalid && s_axis_tready;
            out_acc <= m_axis_tvalid && m_axis_tready;
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                words_out <= words_out + 1;
                if (expected_estimates.size() == 0)
                begin
                    $display("unexpected output word %0d", words_out);
                    errors++;
                end
                else
                begin
                    e = expected_estimates.pop_front();
                    if (m_axis_tdata[30:0] !== e.lat)
                        report_mismatch("est_latitude", $signed(m_axis_tdata[30:0]),
                                        $signed(e.lat));
                    if (m_axis_tdata[62:31] !== e.lon)
                        report_mismatch("est_longitude", $signed(m_axis_tdata[62:31]),
                                        $signed(e.lon));
                    if (m_axis_tuser !== e.settled)
                        report_mismatch("settled", m_axis_tuser, e.settled);
                end
            end
            if (idle_cycles > 5000)
            begin
                $display("watchdog expired");
                $display("TEST FAILED");
                $finish;
            end
        end
        else
        begin
            in_acc <= 1'b0;
            out_acc <= 1'b0;
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [31:0] d);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (a == ADDR_Q) q_noise = d;
        else if (a == ADDR_RLAT) r_lat = d;
        else r_lon = d;
    endtask

    task automatic drain();
        while (pending_fixes.size() != 0 || expected_estimates.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic push_fix(input logic v, input logic [30:0] la, input logic [31:0] lo);
        fix_t f;
        f.fix_valid = v; f.lat = la; f.lon = lo;
        pending_fixes.push_back(f);
    endtask

    function automatic logic [30:0] rand_lat();
        return 31'($signed($urandom_range(0, 1800000000)) - 900000000);
    endfunction

    function automatic logic [31:0] rand_lon();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) return $urandom;
        return 32'(longint'($urandom_range(0, 3600000000)) - 64'sd1800000000);
    endfunction

    // stimulus: phases between register settings
    initial
    begin : stimulus
        int phase, n, i;
        logic [30:0] base_lat;
        logic [31:0] base_lon;
        q_noise = Q_RESET; r_lat = R_RESET; r_lon = R_RESET;
        lat_x = 0; lon_x = 0; lat_p = ONE_Q30; lon_p = ONE_Q30;
        warm_cnt = 0; stable_cnt = 0; settled_q = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, invalid fixes, convergence at reset settings
        push_fix(1'b0, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_fix(1'b1, 31'(-900000000), 32'(-1800000000));
        push_fix(1'b1, 31'd900000000, 32'd1800000000);
        push_fix(1'b0, 31'h4000_0000, 32'h8000_0000);
        push_fix(1'b1, 31'h3FFF_FFFF, 32'h7FFF_FFFF);
        push_fix(1'b1, 31'h4000_0000, 32'h8000_0000);
        for (i = 0; i < 12; i++) push_fix(1'b1, 31'd12345, 32'd54321);
        drain();

        // zero denominator and variance saturation
        apb_write(ADDR_Q, 32'd0);
        apb_write(ADDR_RLAT, 32'd0);
        apb_write(ADDR_RLON, 32'hFFFF_FFFF);
        for (i = 0; i < 4; i++) push_fix(1'b1, rand_lat(), $urandom);
        drain();
        apb_write(ADDR_Q, 32'hFFFF_FFFF);
        for (i = 0; i < 3; i++) push_fix(1'b1, rand_lat(), $urandom);
        drain();

        // random phases
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: apb_write(ADDR_Q, $urandom_range(0, 100000));
                1: apb_write(ADDR_Q, $urandom);
                2: apb_write(ADDR_Q, 32'(Q_RESET));
                default: apb_write(ADDR_Q, 32'd0);
            endcase
            apb_write(ADDR_RLAT, (phase == 3) ? 32'd0 : $urandom);
            apb_write(ADDR_RLON, (phase == 5) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h4000_0000));
            base_lat = rand_lat();
            base_lon = rand_lon();
            for (n = 0; n < 78; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_fix(1'b0, 31'($urandom), $urandom);
                else if ($urandom_range(0, 3) == 0)
                    push_fix(1'b1, rand_lat(), rand_lon());
                else
                    push_fix(1'b1, base_lat + 31'($signed($urandom_range(0, 8)) - 4),
                             base_lon + 32'($signed($urandom_range(0, 8)) - 4));
            end
            // sender holds off until all results are back
            if (phase == 2)
            begin
                while (pending_fixes.size() > 40) @(posedge clk);
                hold_input = 1'b1;
                while (expected_estimates.size() != 0) @(posedge clk);
                hold_input = 1'b0;
            end
            drain();
        end

        $display("covered %0d words, %0d valid fixes, over several noise settings",
                 words_out, valid_fixes);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
